// ----- hdl/tls_pkg.sv -----
// tls_pkg: shared types and constants of the traffic light sequencer
// used by the register file, the phase core, the top level and the checker
// no dependencies

package tls_pkg;

   // phase codes as shown on the result channel
   typedef enum logic [1:0] {
      PHASE_GREEN  = 2'd0,
      PHASE_YELLOW = 2'd1,
      PHASE_RED    = 2'd2
   } phase_type;

   // register indexes of the configuration channel
   localparam logic [2:0] REG_GREEN_SECONDS    = 3'd0;
   localparam logic [2:0] REG_YELLOW_SECONDS   = 3'd1;
   localparam logic [2:0] REG_RED_SECONDS      = 3'd2;
   localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd3;
   localparam logic [2:0] REG_FILTER_TICKS     = 3'd4;

   // register reset values
   localparam logic [6:0]  GREEN_SECONDS_RST    = 7'd59;
   localparam logic [6:0]  YELLOW_SECONDS_RST   = 7'd4;
   localparam logic [6:0]  RED_SECONDS_RST      = 7'd29;
   localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;
   localparam logic [15:0] FILTER_TICKS_RST     = 16'd50;

   // tdata widths of the two streams
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // configuration register set
   typedef struct packed {
      logic [6:0]  green_seconds;
      logic [6:0]  yellow_seconds;
      logic [6:0]  red_seconds;
      logic [15:0] ticks_per_second;
      logic [15:0] filter_ticks;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] units_segments;
      logic [7:0] tens_segments;
      logic       car_stop_lamp;
      logic       red_lamp;
      logic       yellow_lamp;
      logic       green_lamp;
   } result_type;

endpackage

// ----- hdl/tls_csr.sv -----
// tls_csr: configuration registers of the traffic light sequencer
// depends on tls_pkg

module tls_csr import tls_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_data,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode of one register transfer, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GREEN_SECONDS:    cfg_in.green_seconds    = csr_data[6:0];
            REG_YELLOW_SECONDS:   cfg_in.yellow_seconds   = csr_data[6:0];
            REG_RED_SECONDS:      cfg_in.red_seconds      = csr_data[6:0];
            REG_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_data;
            REG_FILTER_TICKS:     cfg_in.filter_ticks     = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_seconds    <= GREEN_SECONDS_RST;
         cfg_ff.yellow_seconds   <= YELLOW_SECONDS_RST;
         cfg_ff.red_seconds      <= RED_SECONDS_RST;
         cfg_ff.ticks_per_second <= TICKS_PER_SECOND_RST;
         cfg_ff.filter_ticks     <= FILTER_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/tls_core.sv -----
// tls_core: phase state, second timer, sensor filter and digit patterns
// one tick is applied per cycle when step is high; result is combinational
// depends on tls_pkg

module tls_core import tls_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        step,
   input  logic        sensor_level,
   output result_type  result
);

   // segment patterns, segment a in bit 0
   localparam logic [7:0] SEG_TABLE [16] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
   };
   localparam logic [3:0] LAMP_GREEN  = 4'b0001;
   localparam logic [3:0] LAMP_YELLOW = 4'b0010;
   localparam logic [3:0] LAMP_RED    = 4'b0100;
   localparam logic [3:0] LAMP_CAR    = 4'b1000;

   phase_type   phase_ff, phase_in;
   logic [6:0]  green_left_ff, green_left_in;
   logic [6:0]  yellow_left_ff, yellow_left_in;
   logic [6:0]  red_left_ff, red_left_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic        tick_run_ff, tick_run_in;
   logic        sense_enable_ff, sense_enable_in;
   logic        filter_run_ff, filter_run_in;
   logic [15:0] filter_count_ff, filter_count_in;
   logic        sense_lock_ff, sense_lock_in;
   logic [3:0]  lamp_ff, lamp_in;

   logic        second;
   logic        show;
   logic [6:0]  shown;
   logic [14:0] tens_prod;
   logic [3:0]  tens_digit;
   logic [6:0]  tens_times_ten;
   logic [3:0]  units_digit;

   // phase logic, timer and sensor filter for one tick
   always_comb begin
      phase_in        = phase_ff;
      green_left_in   = green_left_ff;
      yellow_left_in  = yellow_left_ff;
      red_left_in     = red_left_ff;
      tick_run_in     = tick_run_ff;
      sense_enable_in = sense_enable_ff;
      sense_lock_in   = sense_lock_ff;
      lamp_in         = lamp_ff;
      filter_run_in   = filter_run_ff;
      show            = 1'b0;
      shown           = '0;

      // timer part
      tick_count_in   = tick_run_ff ? tick_count_ff + 16'd1 : '0;
      filter_count_in = filter_run_ff ? filter_count_ff + 16'd1 : filter_count_ff;
      second          = (tick_count_in >= cfg.ticks_per_second);

      case (phase_ff)
         PHASE_GREEN: begin
            tick_run_in     = 1'b1;
            lamp_in         = (lamp_in | LAMP_GREEN) & ~LAMP_RED;
            sense_enable_in = 1'b0;
            red_left_in     = cfg.red_seconds;
            shown           = green_left_ff;
            show            = 1'b1;
            if (second) begin
               tick_count_in = '0;
               if (green_left_ff <= 7'd1) begin
                  green_left_in = '0;
                  phase_in      = PHASE_YELLOW;
               end else begin
                  green_left_in = green_left_ff - 7'd1;
               end
            end
         end
         PHASE_YELLOW: begin
            green_left_in   = cfg.green_seconds;
            lamp_in         = (lamp_in & ~LAMP_GREEN) | LAMP_YELLOW;
            sense_enable_in = 1'b1;
            shown           = yellow_left_ff;
            show            = 1'b1;
            if (second) begin
               tick_count_in = '0;
               if (yellow_left_ff <= 7'd1) begin
                  yellow_left_in = '0;
                  phase_in       = PHASE_RED;
               end else begin
                  yellow_left_in = yellow_left_ff - 7'd1;
               end
            end
         end
         PHASE_RED: begin
            yellow_left_in = cfg.yellow_seconds;
            lamp_in        = (lamp_in & ~(LAMP_GREEN | LAMP_YELLOW)) | LAMP_RED;
            shown          = red_left_ff;
            show           = 1'b1;
            if (second) begin
               tick_count_in = '0;
               if (red_left_ff <= 7'd1) begin
                  red_left_in = '0;
                  phase_in    = PHASE_GREEN;
                  tick_run_in = 1'b0;
               end else begin
                  red_left_in = red_left_ff - 7'd1;
               end
            end
         end
         default: begin
            show = 1'b0;
         end
      endcase

      // sensor filter and car stop latch
      if (sense_enable_in) begin
         if (sensor_level) begin
            sense_lock_in   = 1'b0;
            filter_run_in   = 1'b0;
            filter_count_in = '0;
            lamp_in         = lamp_in & ~LAMP_CAR;
         end else if (!sense_lock_ff) begin
            filter_run_in = 1'b1;
            if (filter_count_in >= cfg.filter_ticks) begin
               filter_run_in = 1'b0;
               sense_lock_in = 1'b1;
               lamp_in       = lamp_in | LAMP_CAR;
            end
         end
      end else begin
         filter_run_in = 1'b0;
         lamp_in       = lamp_in & ~LAMP_CAR;
      end
   end

   // tens and units of the shown count, division by ten through reciprocal
   assign tens_prod      = 15'(shown) * 15'd205;
   assign tens_digit     = tens_prod[14:11];
   assign tens_times_ten = 7'(tens_digit) * 7'd10;
   assign units_digit    = 4'(shown - tens_times_ten);

   // result fields
   always_comb begin
      result.green_lamp     = lamp_in[0];
      result.yellow_lamp    = lamp_in[1];
      result.red_lamp       = lamp_in[2];
      result.car_stop_lamp  = lamp_in[3];
      result.tens_segments  = show ? ~SEG_TABLE[tens_digit] : 8'hFF;
      result.units_segments = show ? ~SEG_TABLE[units_digit] : 8'hFF;
      result.phase          = phase_ff;
   end

   // state registers, advanced once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_GREEN;
         green_left_ff   <= GREEN_SECONDS_RST;
         yellow_left_ff  <= YELLOW_SECONDS_RST;
         red_left_ff     <= RED_SECONDS_RST;
         tick_count_ff   <= '0;
         tick_run_ff     <= 1'b0;
         sense_enable_ff <= 1'b0;
         filter_run_ff   <= 1'b0;
         filter_count_ff <= '0;
         sense_lock_ff   <= 1'b0;
         lamp_ff         <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         green_left_ff   <= green_left_in;
         yellow_left_ff  <= yellow_left_in;
         red_left_ff     <= red_left_in;
         tick_count_ff   <= tick_count_in;
         tick_run_ff     <= tick_run_in;
         sense_enable_ff <= sense_enable_in;
         filter_run_ff   <= filter_run_in;
         filter_count_ff <= filter_count_in;
         sense_lock_ff   <= sense_lock_in;
         lamp_ff         <= lamp_in;
      end
   end

endmodule

// ----- hdl/traffic_light_sequencer_top.sv -----
// traffic_light_sequencer_top: tick stream in, lamp and digit stream out
// depends on tls_pkg, tls_csr and tls_core
//
//   channel   direction  payload
//   req_      in         tdata[0] sensor_level
//   rsp_      out        tdata: lamps, tens and units segments, phase
//   csr_      in         csr_index, csr_data register write
//
// each tick passes an input register and a result register; one tick is
// accepted every cycle while results are taken
// the phase state advances when a tick moves from the input register into
// the result register; a stalled result holds both stages
// synchronous active high reset clears the stages, the phase state and the
// registers to their defaults; csr writes are taken every cycle

module traffic_light_sequencer_top import tls_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // tick stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] sensor_level, [7:1] zero
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] green_lamp, [1] yellow_lamp,
                                              // [2] red_lamp, [3] car_stop_lamp,
                                              // [11:4] tens_segments,
                                              // [19:12] units_segments,
                                              // [21:20] phase, [23:22] zero
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_sensor_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic       advance;

   assign csr_ready = 1'b1;

   tls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tls_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (advance),
      .sensor_level (in_sensor_ff),
      .result       (result)
   );

   // stage handshakes
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sensor_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

// ----- hdl/tls_checker.sv -----
// tls_checker: port level checks of the traffic light sequencer
// depends on tls_pkg; bound to traffic_light_sequencer_top

module tls_checker import tls_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result keeps its transfer pending unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // at most one of the three traffic lamps lit
   a_one_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[2:0]))
      else $error("more than one traffic lamp lit");

   // the lamp of the reported phase is lit, car stop lamp dark in green
   a_phase_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[21:20] == PHASE_GREEN  && rsp_tdata[0] && !rsp_tdata[3]) ||
         (rsp_tdata[21:20] == PHASE_YELLOW && rsp_tdata[1]) ||
         (rsp_tdata[21:20] == PHASE_RED    && rsp_tdata[2]))
      else $error("lamps disagree with phase");

endmodule

bind traffic_light_sequencer_top tls_checker u_tls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/tb_traffic_light_sequencer_top.sv -----
// tb_traffic_light_sequencer_top: self-checking testbench of the traffic light sequencer
// drives tick transfers and register writes, predicts every result and compares it in order
// depends on tls_pkg and traffic_light_sequencer_top

module tb_traffic_light_sequencer_top;
   import tls_pkg::*;

   // lamp bit positions in the predicted lamp register
   localparam int LAMP_GREEN_BIT  = 0;
   localparam int LAMP_YELLOW_BIT = 1;
   localparam int LAMP_RED_BIT    = 2;
   localparam int LAMP_CAR_BIT    = 3;

   localparam int RESULT_W      = $bits(result_type);
   localparam int IDLE_PERCENT  = 28;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ROUNDS = 8;
   localparam int TIME_LIMIT    = 400000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [2:0]            csr_index;
   logic [15:0]           csr_data;

   // predicted configuration and phase state
   cfg_type    cfg_now;
   phase_type  phase_st;
   logic [6:0] green_left;
   logic [6:0] yellow_left;
   logic [6:0] red_left;
   logic [15:0] tick_cnt;
   logic [15:0] filter_cnt;
   logic       tick_run;
   logic       sense_on;
   logic       filter_run;
   logic       sense_lock;
   logic [3:0] lamps;

   result_type expected_results[$];
   int         error_count   = 0;
   int         result_count  = 0;
   int         hold_request  = 0;
   bit         steady_mode   = 1'b0;

   traffic_light_sequencer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run time limit
   initial begin
      #TIME_LIMIT;
      $display("tb_traffic_light_sequencer_top: done, errors");
      $finish;
   end

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // inverted seven-segment pattern, segment a in bit 0
   function automatic logic [7:0] digit_segments(input logic [3:0] digit);
      logic [7:0] lit;
      case (digit)
         4'h0: lit = 8'h3F;
         4'h1: lit = 8'h06;
         4'h2: lit = 8'h5B;
         4'h3: lit = 8'h4F;
         4'h4: lit = 8'h66;
         4'h5: lit = 8'h6D;
         4'h6: lit = 8'h7D;
         4'h7: lit = 8'h07;
         4'h8: lit = 8'h7F;
         4'h9: lit = 8'h6F;
         4'hA: lit = 8'h77;
         4'hB: lit = 8'h7C;
         4'hC: lit = 8'h39;
         4'hD: lit = 8'h5E;
         4'hE: lit = 8'h79;
         default: lit = 8'h71;
      endcase
      return ~lit;
   endfunction

   // one second off a countdown, stuck at zero once it ends
   function automatic logic [6:0] next_count(input logic [6:0] left);
      return (left <= 7'd1) ? 7'd0 : left - 7'd1;
   endfunction

   task automatic reset_model();
      cfg_now.green_seconds    = GREEN_SECONDS_RST;
      cfg_now.yellow_seconds   = YELLOW_SECONDS_RST;
      cfg_now.red_seconds      = RED_SECONDS_RST;
      cfg_now.ticks_per_second = TICKS_PER_SECOND_RST;
      cfg_now.filter_ticks     = FILTER_TICKS_RST;
      phase_st    = PHASE_GREEN;
      green_left  = GREEN_SECONDS_RST;
      yellow_left = YELLOW_SECONDS_RST;
      red_left    = RED_SECONDS_RST;
      tick_cnt    = '0;
      filter_cnt  = '0;
      tick_run    = 1'b0;
      sense_on    = 1'b0;
      filter_run  = 1'b0;
      sense_lock  = 1'b0;
      lamps       = '0;
   endtask

   // advances the phase state by one tick and returns the lamps and digits it shows
   function automatic result_type advance_tick(input logic level);
      result_type res;
      phase_type  ph;
      logic [6:0] shown;
      logic       show;
      logic       second;
      ph    = phase_st;
      shown = '0;
      show  = 1'b1;

      // second timer and filter timer
      if (tick_run) tick_cnt = tick_cnt + 16'd1;
      else tick_cnt = '0;
      if (filter_run) filter_cnt = filter_cnt + 16'd1;
      second = (tick_cnt >= cfg_now.ticks_per_second);

      // phase sequencing, each phase reloads the count of the one before
      case (ph)
         PHASE_GREEN: begin
            tick_run = 1'b1;
            lamps[LAMP_GREEN_BIT] = 1'b1;
            lamps[LAMP_RED_BIT] = 1'b0;
            sense_on = 1'b0;
            red_left = cfg_now.red_seconds;
            shown = green_left;
            if (second) begin
               tick_cnt = '0;
               if (green_left <= 7'd1) phase_st = PHASE_YELLOW;
               green_left = next_count(green_left);
            end
         end
         PHASE_YELLOW: begin
            green_left = cfg_now.green_seconds;
            lamps[LAMP_GREEN_BIT] = 1'b0;
            lamps[LAMP_YELLOW_BIT] = 1'b1;
            sense_on = 1'b1;
            shown = yellow_left;
            if (second) begin
               tick_cnt = '0;
               if (yellow_left <= 7'd1) phase_st = PHASE_RED;
               yellow_left = next_count(yellow_left);
            end
         end
         PHASE_RED: begin
            yellow_left = cfg_now.yellow_seconds;
            lamps[LAMP_GREEN_BIT] = 1'b0;
            lamps[LAMP_YELLOW_BIT] = 1'b0;
            lamps[LAMP_RED_BIT] = 1'b1;
            shown = red_left;
            if (second) begin
               tick_cnt = '0;
               // back to green, the second timer pauses for one tick
               if (red_left <= 7'd1) begin
                  phase_st = PHASE_GREEN;
                  tick_run = 1'b0;
               end
               red_left = next_count(red_left);
            end
         end
         default: show = 1'b0;
      endcase

      // vehicle sensor filter and car-stop latch
      if (sense_on) begin
         if (level) begin
            sense_lock = 1'b0;
            filter_run = 1'b0;
            filter_cnt = '0;
            lamps[LAMP_CAR_BIT] = 1'b0;
         end else if (!sense_lock) begin
            filter_run = 1'b1;
            if (filter_cnt >= cfg_now.filter_ticks) begin
               filter_run = 1'b0;
               sense_lock = 1'b1;
               lamps[LAMP_CAR_BIT] = 1'b1;
            end
         end
      end else begin
         filter_run = 1'b0;
         lamps[LAMP_CAR_BIT] = 1'b0;
      end

      res.green_lamp    = lamps[LAMP_GREEN_BIT];
      res.yellow_lamp   = lamps[LAMP_YELLOW_BIT];
      res.red_lamp      = lamps[LAMP_RED_BIT];
      res.car_stop_lamp = lamps[LAMP_CAR_BIT];
      if (show) begin
         res.tens_segments  = digit_segments(4'(shown / 7'd10));
         res.units_segments = digit_segments(4'(shown % 7'd10));
      end else begin
         res.tens_segments  = 8'hFF;
         res.units_segments = 8'hFF;
      end
      res.phase = ph;
      return res;
   endfunction

   // one register write transfer, followed by a quiet spell with csr_valid low
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_GREEN_SECONDS:    cfg_now.green_seconds    = value[6:0];
         REG_YELLOW_SECONDS:   cfg_now.yellow_seconds   = value[6:0];
         REG_RED_SECONDS:      cfg_now.red_seconds      = value[6:0];
         REG_TICKS_PER_SECOND: cfg_now.ticks_per_second = value;
         REG_FILTER_TICKS:     cfg_now.filter_ticks     = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // one tick transfer with a random gap in front; valid stays up for the next tick
   task automatic send_tick(input logic level);
      while (!steady_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, level};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(advance_tick(level));
      @(negedge clock);
   endtask

   // runs of low and high sensor levels, at most four ticks longer than the filter and at most 40 long
   task automatic send_sensor_runs(input int count);
      int   sent;
      int   run_len;
      int   span;
      logic level;
      sent  = 0;
      level = 1'b1;
      while (sent < count) begin
         level = ~level;
         span = (cfg_now.filter_ticks > 16'd36) ? 40 : int'(cfg_now.filter_ticks) + 4;
         if ($urandom_range(0, 3) == 0) run_len = $urandom_range(1, 3);
         else run_len = $urandom_range(1, span);
         for (int k = 0; k < run_len && sent < count; k++) begin
            send_tick(level);
            sent++;
         end
      end
   endtask

   // stop offering ticks and wait until every result is in
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_seconds();
      case ($urandom_range(0, 11))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd99;
         3: return 16'd127 | (16'($urandom) & 16'hFF80);
         default: return 16'($urandom_range(1, 12)) | (16'($urandom) & 16'hFF80);
      endcase
   endfunction

   task automatic configure_random();
      logic [15:0] tps;
      logic [15:0] filt;
      case ($urandom_range(0, 9))
         0: tps = 16'd0;
         1: tps = 16'hFFFF;
         default: tps = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
         0: filt = 16'd0;
         1: filt = 16'hFFFF;
         default: filt = 16'($urandom_range(1, 12));
      endcase
      write_reg(REG_GREEN_SECONDS, pick_seconds());
      write_reg(REG_YELLOW_SECONDS, pick_seconds());
      write_reg(REG_RED_SECONDS, pick_seconds());
      write_reg(REG_TICKS_PER_SECOND, tps);
      write_reg(REG_FILTER_TICKS, filt);
   endtask

   // all-ones writes: counts of 127, longest second and filter
   task automatic test_register_extremes();
      write_reg(REG_GREEN_SECONDS, 16'hFFFF);
      write_reg(REG_YELLOW_SECONDS, 16'hFFFF);
      write_reg(REG_RED_SECONDS, 16'hFFFF);
      write_reg(REG_TICKS_PER_SECOND, 16'hFFFF);
      write_reg(REG_FILTER_TICKS, 16'hFFFF);
      for (int k = 0; k < 6; k++) send_tick(k[0]);
   endtask

   // writes beyond the last register must change nothing
   task automatic test_ignored_index();
      for (int idx = int'(REG_FILTER_TICKS) + 1; idx < 8; idx++)
         write_reg(3'(idx), 16'($urandom));
      for (int k = 0; k < 3; k++) send_tick(k[0]);
   endtask

   // long stretch with no gaps on either side, every tick a second
   task automatic test_steady_stream();
      steady_mode = 1'b1;
      write_reg(REG_TICKS_PER_SECOND, 16'd0);
      write_reg(REG_GREEN_SECONDS, 16'($urandom_range(0, 6)));
      write_reg(REG_YELLOW_SECONDS, 16'($urandom_range(0, 6)));
      write_reg(REG_RED_SECONDS, 16'($urandom_range(0, 6)));
      write_reg(REG_FILTER_TICKS, 16'($urandom_range(0, 4)));
      send_sensor_runs(200);
      steady_mode = 1'b0;
   endtask

   // short phases: red loaded as zero, filter of zero, every tick a second
   task automatic test_fast_cycle();
      logic [15:0] levels;
      levels = 16'b0010_0110_0001_1000;
      write_reg(REG_GREEN_SECONDS, 16'd1);
      write_reg(REG_YELLOW_SECONDS, 16'd2);
      write_reg(REG_RED_SECONDS, 16'd0);
      write_reg(REG_TICKS_PER_SECOND, 16'd0);
      write_reg(REG_FILTER_TICKS, 16'd0);
      for (int k = 0; k < 16; k++) send_tick(levels[k]);
   endtask

   // receiver stops for a long stretch while ticks keep coming
   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      send_sensor_runs(60);
   endtask

   // rounds of random settings with random sensor runs
   task automatic test_random_settings();
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         drain_results();
         configure_random();
         send_sensor_runs(90);
      end
   endtask

   // result receiver: random stalls, or a counted hold when asked
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // result checker: each transfer against the oldest prediction
   initial begin
      result_type want;
      result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_W-1:0]);
            result_count++;
            if (expected_results.size() == 0) begin
               log_error($sformatf("result %0d: unexpected, tdata %h", result_count, rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (got.green_lamp !== want.green_lamp ||
                   got.yellow_lamp !== want.yellow_lamp ||
                   got.red_lamp !== want.red_lamp ||
                   got.car_stop_lamp !== want.car_stop_lamp ||
                   got.tens_segments !== want.tens_segments ||
                   got.units_segments !== want.units_segments ||
                   got.phase !== want.phase ||
                   rsp_tdata[RSP_DATA_W-1:RESULT_W] !== '0) begin
                  log_error({
                     $sformatf(
                        "result %0d: expected g%b y%b r%b car%b tens %h units %h phase %0d,",
                        result_count, want.green_lamp, want.yellow_lamp, want.red_lamp,
                        want.car_stop_lamp, want.tens_segments, want.units_segments,
                        want.phase),
                     $sformatf(
                        " got g%b y%b r%b car%b tens %h units %h phase %0d pad %b",
                        got.green_lamp, got.yellow_lamp, got.red_lamp, got.car_stop_lamp,
                        got.tens_segments, got.units_segments, got.phase,
                        rsp_tdata[RSP_DATA_W-1:RESULT_W])});
               end
            end
         end
      end
   end

   // test sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      reset_model();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_extremes();
      drain_results();
      test_ignored_index();
      drain_results();
      test_steady_stream();
      drain_results();
      test_fast_cycle();
      test_backpressure();
      test_random_settings();
      drain_results();

      if (expected_results.size() != 0)
         log_error($sformatf("%0d results never arrived", expected_results.size()));
      if (error_count == 0) begin
         $display("tb_traffic_light_sequencer_top: done, clean");
      end else begin
         $display("tb_traffic_light_sequencer_top: done, errors");
      end
      $finish;
   end

endmodule
